// ----- design/srbc_pkg.sv -----
// Package for the sorted range bin counter: sizes, request kinds and the
// command / status structs between controller and datapath.
// No dependencies.
package srbc_pkg;

   // Table geometry
   localparam int MAX_RANGES  = 64;
   localparam int IDX_W       = 6;   // bits to address one range entry
   localparam int PTR_W       = 7;   // pointer also holds MAX_RANGES itself
   localparam int VAL_W       = 32;
   localparam int CNT_W       = 32;

   // Stream widths
   localparam int REQ_DATA_W  = 104; // 102 bits of fields padded to bytes
   localparam int REQ_USER_W  = 2;
   localparam int RSP_DATA_W  = 72;

   // Configuration port
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 7;
   localparam logic [CSR_IDX_W-1:0] CSR_SORT_ORDER    = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RANGES_IN_USE = 1'd1;

   // Request kinds carried on req_tuser
   typedef enum logic [1:0] {
      KIND_LOAD  = 2'd0,
      KIND_VALUE = 2'd1,
      KIND_READ  = 2'd2,
      KIND_START = 2'd3
   } kind_type;

   // Controller to datapath
   typedef struct packed {
      logic accept;    // take the request on the input now
      logic advance;   // step the pointer to the next range, fetch it
      logic match;     // current range holds the value: bump its count
      logic push;      // load the response register
   } srbc_cmd_type;

   // Datapath to controller
   typedef struct packed {
      kind_type req_kind;  // kind of the request waiting on the input
      logic     ptr_lt_n;  // pointer still inside the active table
      logic     next_lt_n; // pointer + 1 still inside the active table
      logic     skip;      // value lies before the current range
      logic     in_range;  // value lies inside the current range
      logic     rsp_free;  // response register can take a new result
   } srbc_sts_type;

endpackage

// ----- design/sorted_range_bin_counter.sv -----
// Sorted range bin counter, top level: controller plus datapath.
// Depends on srbc_pkg, srbc_ctrl and srbc_dp.
//
// Counts a sorted stream of signed 32-bit values into a table of up to 64
// ranges (low inclusive, high exclusive) sorted the same way, by merging with
// a range pointer that only moves forward; each request (load, value, read,
// start) gives one response. A request is accepted in the idle state and
// loads the response register from the finish state; a value request with
// ranges left first walks the evaluate state, each step one bounds memory read
// then the compare, until a range holds the value, lies past it, or the table
// is exhausted. A response waiting on rsp_tready holds the block until it is
// taken or the register frees. Configuration (sort_order at index 0,
// ranges_in_use at index 1) must be written while idle; the block itself does
// not enforce this. There is no clearing pass after reset.
module sorted_range_bin_counter (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // [5:0] range_index, [37:6] range_low, [69:38] range_high,
   // [101:70] value, [103:102] zero
   input  logic [srbc_pkg::REQ_DATA_W-1:0]      req_tdata,
   // [1:0] kind
   input  logic [srbc_pkg::REQ_USER_W-1:0]      req_tuser,
   // response channel
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [0] matched, [6:1] hit_index, [38:7] count_value,
   // [70:39] match_total, [71] exhausted
   output logic [srbc_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // configuration writes
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [srbc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [srbc_pkg::CSR_DATA_W-1:0]      csr_data
);
   import srbc_pkg::*;

   srbc_cmd_type cmd;
   srbc_sts_type sts;

   srbc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   srbc_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .cmd        (cmd),
      .sts        (sts)
   );

endmodule

// ----- design/srbc_ctrl.sv -----
// Controller of the sorted range bin counter: one-hot state machine that
// sequences accept, range merge steps and the response.
// Depends on srbc_pkg.
module srbc_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  srbc_pkg::srbc_sts_type sts,
   output srbc_pkg::srbc_cmd_type cmd
);
   import srbc_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_EVAL = 3'b010,
      ST_FIN  = 3'b100
   } state_type;

   state_type state_ff, state_in;

   assign req_tready = (state_ff == ST_IDLE);

   // Next state and commands
   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               if (sts.req_kind == KIND_VALUE && sts.ptr_lt_n) begin
                  state_in = ST_EVAL;
               end else begin
                  state_in = ST_FIN;
               end
            end
         end
         ST_EVAL: begin
            if (sts.skip) begin
               state_in = ST_FIN;
            end else if (sts.in_range) begin
               cmd.match = 1'b1;
               state_in  = ST_FIN;
            end else begin
               cmd.advance = 1'b1;
               state_in    = sts.next_lt_n ? ST_EVAL : ST_FIN;
            end
         end
         ST_FIN: begin
            if (sts.rsp_free) begin
               cmd.push = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- design/srbc_dp.sv -----
// Datapath of the sorted range bin counter: bound and count memories,
// range pointer, total, compares, configuration and response registers.
// Depends on srbc_pkg.
module srbc_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   // request payload
   input  logic [srbc_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  logic [srbc_pkg::REQ_USER_W-1:0]      req_tuser,
   // response channel
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [srbc_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // configuration writes
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [srbc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [srbc_pkg::CSR_DATA_W-1:0]      csr_data,
   // controller link
   input  srbc_pkg::srbc_cmd_type               cmd,
   output srbc_pkg::srbc_sts_type               sts
);
   import srbc_pkg::*;

   // Request fields
   kind_type          req_kind;
   logic [IDX_W-1:0]  req_idx;
   logic [VAL_W-1:0]  req_low;
   logic [VAL_W-1:0]  req_high;
   logic [VAL_W-1:0]  req_value;

   assign req_kind  = kind_type'(req_tuser);
   assign req_idx   = req_tdata[5:0];
   assign req_low   = req_tdata[37:6];
   assign req_high  = req_tdata[69:38];
   assign req_value = req_tdata[101:70];

   // Configuration registers
   logic             sort_ff;
   logic [PTR_W-1:0] ranges_ff;
   logic [PTR_W-1:0] n_act;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         sort_ff   <= 1'b0;
         ranges_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_SORT_ORDER:    sort_ff   <= csr_data[0];
            CSR_RANGES_IN_USE: ranges_ff <= csr_data[PTR_W-1:0];
            default: ;
         endcase
      end
   end

   // Active table size, clamped to the table depth
   assign n_act = (ranges_ff > PTR_W'(MAX_RANGES)) ? PTR_W'(MAX_RANGES) : ranges_ff;

   // Held request
   kind_type         kind_ff;
   logic [VAL_W-1:0] val_ff;

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         kind_ff <= req_kind;
         val_ff  <= req_value;
      end
   end

   // Range pointer and its successor
   logic [PTR_W-1:0] ptr_ff;
   logic [PTR_W-1:0] ptr_nxt;
   logic             start_hit;

   assign ptr_nxt   = ptr_ff + PTR_W'(1);
   assign start_hit = cmd.accept && (req_kind == KIND_START);

   always_ff @(posedge clock) begin
      if (reset || start_hit) begin
         ptr_ff <= '0;
      end else if (cmd.advance) begin
         ptr_ff <= ptr_nxt;
      end
   end

   // Memory read address: read item index, next range, or current range
   logic [IDX_W-1:0] rd_idx;
   logic             rd_en;

   always_comb begin
      if (cmd.advance) begin
         rd_idx = ptr_nxt[IDX_W-1:0];
      end else if (req_kind == KIND_READ) begin
         rd_idx = req_idx;
      end else begin
         rd_idx = ptr_ff[IDX_W-1:0];
      end
   end

   assign rd_en = cmd.accept | cmd.advance;

   // Bounds memory, {high, low} per entry
   logic [2*VAL_W-1:0] bnd_mem [MAX_RANGES];
   logic [2*VAL_W-1:0] bnd_rd_ff;

   always_ff @(posedge clock) begin
      if (cmd.accept && req_kind == KIND_LOAD) begin
         bnd_mem[req_idx] <= {req_high, req_low};
      end
      if (rd_en) begin
         bnd_rd_ff <= bnd_mem[rd_idx];
      end
   end

   // Count memory with per-entry valid bits; invalid entries read as zero
   logic [CNT_W-1:0]      cnt_mem [MAX_RANGES];
   logic [CNT_W-1:0]      cnt_rd_ff;
   logic                  cnt_rd_vld_ff;
   logic [MAX_RANGES-1:0] cnt_vld_ff;
   logic [CNT_W-1:0]      cnt_cur;
   logic [CNT_W-1:0]      cnt_new;

   assign cnt_cur = cnt_rd_vld_ff ? cnt_rd_ff : '0;
   assign cnt_new = (cnt_cur == '1) ? cnt_cur : cnt_cur + CNT_W'(1);

   always_ff @(posedge clock) begin
      if (cmd.match) begin
         cnt_mem[ptr_ff[IDX_W-1:0]] <= cnt_new;
      end
      if (rd_en) begin
         cnt_rd_ff     <= cnt_mem[rd_idx];
         cnt_rd_vld_ff <= cnt_vld_ff[rd_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || start_hit) begin
         cnt_vld_ff <= '0;
      end else if (cmd.match) begin
         cnt_vld_ff[ptr_ff[IDX_W-1:0]] <= 1'b1;
      end
   end

   // Total of matched values, saturating
   logic [CNT_W-1:0] total_ff;

   always_ff @(posedge clock) begin
      if (reset || start_hit) begin
         total_ff <= '0;
      end else if (cmd.match && total_ff != '1) begin
         total_ff <= total_ff + CNT_W'(1);
      end
   end

   // Compares against the fetched range
   logic lt_low;
   logic lt_high;

   assign lt_low  = $signed(val_ff) < $signed(bnd_rd_ff[VAL_W-1:0]);
   assign lt_high = $signed(val_ff) < $signed(bnd_rd_ff[2*VAL_W-1:VAL_W]);

   // Result fields gathered while the request is worked on
   logic             res_match_ff;
   logic [IDX_W-1:0] res_hit_ff;
   logic [CNT_W-1:0] res_cnt_ff;
   logic [CNT_W-1:0] out_cnt;

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         res_match_ff <= 1'b0;
         res_hit_ff   <= (req_kind == KIND_READ) ? req_idx : '0;
         res_cnt_ff   <= '0;
      end else if (cmd.match) begin
         res_match_ff <= 1'b1;
         res_hit_ff   <= ptr_ff[IDX_W-1:0];
         res_cnt_ff   <= cnt_new;
      end
   end

   assign out_cnt = (kind_ff == KIND_READ) ? cnt_cur : res_cnt_ff;

   // Response register
   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.push) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         rsp_data_ff <= {~sts.ptr_lt_n, total_ff, out_cnt, res_hit_ff, res_match_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Status to the controller
   assign sts.req_kind  = req_kind;
   assign sts.ptr_lt_n  = ptr_ff < n_act;
   assign sts.next_lt_n = ptr_nxt < n_act;
   assign sts.skip      = sort_ff ? ~lt_high : lt_low;
   assign sts.in_range  = sort_ff ? ~lt_low : lt_high;
   assign sts.rsp_free  = ~rsp_valid_ff | rsp_tready;

endmodule
